/* rtl/ftmd_pkg.sv */
// Shared types, constants and character tables for the float to decimal text unit.
package ftmd_pkg;

    localparam int unsigned FLOAT_W    = 32;
    localparam int unsigned EXP_W      = 8;
    localparam int unsigned MANT_W     = 23;
    localparam int unsigned PROD_W     = 31;
    localparam int unsigned BIN_W      = 32;
    localparam int unsigned DIGITS     = 10;
    localparam int unsigned BCD_W      = 4 * DIGITS;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned PTR_W      = 4;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned CONV_STEPS = BIN_W / BITS_PER_STEP;

    localparam logic [EXP_W-1:0]  EXP_SPECIAL = 8'hFF;
    localparam logic [EXP_W-1:0]  EXP_OFFSET  = 8'd147;
    localparam logic [PROD_W-1:0] MILLI_SCALE = 31'd125;

    localparam logic [KIND_W-1:0] KIND_NUMBER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAN      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INF      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'("-");
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'(".");
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'("0");

    // Text positions: minus sign, seven integer digits, point, three fraction digits.
    localparam logic [PTR_W-1:0] PTR_SIGN       = 4'd0;
    localparam logic [PTR_W-1:0] PTR_FIRST_DIG  = 4'd1;
    localparam logic [PTR_W-1:0] PTR_UNITS      = 4'd7;
    localparam logic [PTR_W-1:0] PTR_DOT        = 4'd8;
    localparam logic [PTR_W-1:0] PTR_NUM_LAST   = 4'd11;
    localparam logic [PTR_W-1:0] PTR_NAN_LAST   = 4'd2;
    localparam logic [PTR_W-1:0] PTR_INF_LAST   = 4'd3;
    localparam logic [PTR_W-1:0] PTR_OVF_LAST   = 4'd8;

    typedef struct packed {
        logic             load;
        logic             scale;
        logic             step;
        logic             out_load;
        logic [PTR_W-1:0] ptr;
    } dp_cmd_t;

    typedef struct packed {
        logic [PTR_W-1:0] first_ptr;
        logic [PTR_W-1:0] jump_ptr;
        logic [PTR_W-1:0] last_ptr;
    } dp_sts_t;

    // Characters of the fixed strings; unsigned forms start one place later.
    function automatic logic [CHAR_W-1:0] fixed_char(
        input logic [KIND_W-1:0] kind,
        input logic [PTR_W-1:0]  ptr
    );
        logic [CHAR_W-1:0] ch;
        ch = CHAR_MINUS;
        case (kind)
            KIND_NAN: begin
                case (ptr)
                    4'd0:    ch = 7'("N");
                    4'd1:    ch = 7'("a");
                    default: ch = 7'("N");
                endcase
            end
            KIND_INF: begin
                case (ptr)
                    4'd1:    ch = 7'("I");
                    4'd2:    ch = 7'("n");
                    4'd3:    ch = 7'("f");
                    default: ch = CHAR_MINUS;
                endcase
            end
            default: begin
                case (ptr)
                    4'd1:    ch = 7'("O");
                    4'd2:    ch = 7'("v");
                    4'd3:    ch = 7'("e");
                    4'd4:    ch = 7'("r");
                    4'd5:    ch = 7'("f");
                    4'd6:    ch = 7'("l");
                    4'd7:    ch = 7'("o");
                    4'd8:    ch = 7'("w");
                    default: ch = CHAR_MINUS;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

/* rtl/ftmd_dp.sv */
// Datapath: scaling, binary to decimal conversion and character selection.
module ftmd_dp (
    input  logic                                   aclk,
    input  logic [ftmd_pkg::FLOAT_W-1:0]           s_float_bits,
    input  ftmd_pkg::dp_cmd_t                      cmd,
    output ftmd_pkg::dp_sts_t                      sts,
    output logic [ftmd_pkg::CHAR_W-1:0]            m_character,
    output logic [ftmd_pkg::KIND_W-1:0]            m_kind,
    output logic                                   m_last
);

    logic                               neg_reg, neg_next;
    logic [ftmd_pkg::EXP_W-1:0]         expo_reg, expo_next;
    logic [ftmd_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [ftmd_pkg::KIND_W-1:0]        kind_reg, kind_next;
    logic [ftmd_pkg::BIN_W-1:0]         bin_reg, bin_next;
    logic [ftmd_pkg::BCD_W-1:0]         bcd_reg, bcd_next;
    logic [ftmd_pkg::CHAR_W-1:0]        char_reg, char_next;
    logic [ftmd_pkg::KIND_W-1:0]        okind_reg, okind_next;
    logic                               olast_reg, olast_next;

    logic [ftmd_pkg::EXP_W-1:0]         in_expo;
    logic [ftmd_pkg::MANT_W-1:0]        in_mant;
    logic [ftmd_pkg::EXP_W-1:0]         up_amt;
    logic [ftmd_pkg::EXP_W-1:0]         dn_amt;
    logic [2*ftmd_pkg::BIN_W-2:0]       wide;
    logic                               too_big;
    logic [ftmd_pkg::BIN_W-1:0]         scaled;
    logic [ftmd_pkg::BCD_W-1:0]         bcd_t;
    logic [ftmd_pkg::BIN_W-1:0]         bin_t;
    logic                               nonzero;
    logic [ftmd_pkg::PTR_W-1:0]         dig_start;
    logic [ftmd_pkg::PTR_W-1:0]         dig_idx;
    logic [3:0]                         digit;
    logic [ftmd_pkg::CHAR_W-1:0]        cur_char;

    assign in_expo = s_float_bits[ftmd_pkg::FLOAT_W-2 -: ftmd_pkg::EXP_W];
    assign in_mant = s_float_bits[ftmd_pkg::MANT_W-1:0];

    // Scaling by a power of two: left shifts that lose set bits overflow.
    always_comb begin
        up_amt  = expo_reg - ftmd_pkg::EXP_OFFSET;
        dn_amt  = ftmd_pkg::EXP_OFFSET - expo_reg;
        wide    = {{(ftmd_pkg::BIN_W){1'b0}}, prod_reg} << up_amt[4:0];
        too_big = 1'b0;
        scaled  = '0;
        if (expo_reg == '0) begin
            scaled = '0;
        end else if (expo_reg >= ftmd_pkg::EXP_OFFSET) begin
            too_big = (up_amt[ftmd_pkg::EXP_W-1:5] != '0) ||
                      (wide[2*ftmd_pkg::BIN_W-2:ftmd_pkg::BIN_W] != '0);
            scaled  = wide[ftmd_pkg::BIN_W-1:0];
        end else if (dn_amt[ftmd_pkg::EXP_W-1:5] != '0) begin
            scaled = '0;
        end else begin
            scaled = {1'b0, prod_reg} >> dn_amt[4:0];
        end
    end

    // Four shift-and-add-three steps of the double dabble per cycle.
    always_comb begin
        bcd_t = bcd_reg;
        bin_t = bin_reg;
        for (int s = 0; s < ftmd_pkg::BITS_PER_STEP; s++) begin
            for (int d = 0; d < ftmd_pkg::DIGITS; d++) begin
                if (bcd_t[4*d +: 4] >= 4'd5) begin
                    bcd_t[4*d +: 4] = bcd_t[4*d +: 4] + 4'd3;
                end
            end
            bcd_t = {bcd_t[ftmd_pkg::BCD_W-2:0], bin_t[ftmd_pkg::BIN_W-1]};
            bin_t = {bin_t[ftmd_pkg::BIN_W-2:0], 1'b0};
        end
    end

    // The most significant nonzero integer digit, or else the units digit, sets where the digits begin.
    always_comb begin
        nonzero   = (bcd_reg != '0);
        dig_start = ftmd_pkg::PTR_UNITS;
        for (int d = 4; d < ftmd_pkg::DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] != 4'd0) begin
                dig_start = ftmd_pkg::PTR_W'(ftmd_pkg::DIGITS - d);
            end
        end
    end

    always_comb begin
        sts.jump_ptr = (kind_reg == ftmd_pkg::KIND_NUMBER) ? dig_start
                                                           : ftmd_pkg::PTR_FIRST_DIG;
        case (kind_reg)
            ftmd_pkg::KIND_NUMBER: begin
                sts.last_ptr  = ftmd_pkg::PTR_NUM_LAST;
                sts.first_ptr = (neg_reg && nonzero) ? ftmd_pkg::PTR_SIGN : dig_start;
            end
            ftmd_pkg::KIND_NAN: begin
                sts.last_ptr  = ftmd_pkg::PTR_NAN_LAST;
                sts.first_ptr = ftmd_pkg::PTR_SIGN;
            end
            ftmd_pkg::KIND_INF: begin
                sts.last_ptr  = ftmd_pkg::PTR_INF_LAST;
                sts.first_ptr = neg_reg ? ftmd_pkg::PTR_SIGN : ftmd_pkg::PTR_FIRST_DIG;
            end
            default: begin
                sts.last_ptr  = ftmd_pkg::PTR_OVF_LAST;
                sts.first_ptr = neg_reg ? ftmd_pkg::PTR_SIGN : ftmd_pkg::PTR_FIRST_DIG;
            end
        endcase
    end

    always_comb begin
        if (cmd.ptr > ftmd_pkg::PTR_DOT) begin
            dig_idx = ftmd_pkg::PTR_NUM_LAST - cmd.ptr;
        end else begin
            dig_idx = ftmd_pkg::PTR_DOT + 4'd2 - cmd.ptr;
        end
        digit = bcd_reg[4*dig_idx +: 4];
        if (kind_reg != ftmd_pkg::KIND_NUMBER) begin
            cur_char = ftmd_pkg::fixed_char(kind_reg, cmd.ptr);
        end else if (cmd.ptr == ftmd_pkg::PTR_SIGN) begin
            cur_char = ftmd_pkg::CHAR_MINUS;
        end else if (cmd.ptr == ftmd_pkg::PTR_DOT) begin
            cur_char = ftmd_pkg::CHAR_DOT;
        end else begin
            cur_char = ftmd_pkg::CHAR_ZERO + {3'b000, digit};
        end
    end

    always_comb begin
        neg_next   = neg_reg;
        expo_next  = expo_reg;
        prod_next  = prod_reg;
        kind_next  = kind_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        char_next  = char_reg;
        okind_next = okind_reg;
        olast_next = olast_reg;
        if (cmd.load) begin
            neg_next  = s_float_bits[ftmd_pkg::FLOAT_W-1];
            expo_next = in_expo;
            prod_next = {7'd0, 1'b1, in_mant} * ftmd_pkg::MILLI_SCALE;
            if (in_expo == ftmd_pkg::EXP_SPECIAL) begin
                kind_next = (in_mant == '0) ? ftmd_pkg::KIND_INF : ftmd_pkg::KIND_NAN;
            end else begin
                kind_next = ftmd_pkg::KIND_NUMBER;
            end
        end
        if (cmd.scale) begin
            bin_next = scaled;
            bcd_next = '0;
            if (kind_reg == ftmd_pkg::KIND_NUMBER && too_big) begin
                kind_next = ftmd_pkg::KIND_OVERFLOW;
            end
        end
        if (cmd.step) begin
            bin_next = bin_t;
            bcd_next = bcd_t;
        end
        if (cmd.out_load) begin
            char_next  = cur_char;
            okind_next = kind_reg;
            olast_next = (cmd.ptr == sts.last_ptr);
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        expo_reg  <= expo_next;
        prod_reg  <= prod_next;
        kind_reg  <= kind_next;
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        char_reg  <= char_next;
        okind_reg <= okind_next;
        olast_reg <= olast_next;
    end

    assign m_character = char_reg;
    assign m_kind      = okind_reg;
    assign m_last      = olast_reg;

endmodule

/* rtl/ftmd_ctrl.sv */
// Controller: sequences scaling, conversion and character output for one item.
module ftmd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ftmd_pkg::dp_sts_t sts,
    output ftmd_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [ftmd_pkg::PTR_W-1:0]    ptr_reg, ptr_next;
    logic [ftmd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.ptr      = ptr_reg;
        s_ready      = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                cnt_next   = '0;
                state_next = ST_CONV;
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ftmd_pkg::CNT_W'(ftmd_pkg::CONV_STEPS - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                ptr_next   = sts.first_ptr;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    if (ptr_reg == sts.last_ptr) begin
                        state_next = ST_IDLE;
                    end else if (ptr_reg == ftmd_pkg::PTR_SIGN) begin
                        ptr_next = sts.jump_ptr;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/float_to_milli_decimal_text_unit.sv */
// Top level of the single-precision float to three-decimal ASCII text unit.
// Usage:
//   The input channel (s_valid, s_ready, s_float_bits) takes one raw
//   single-precision bit pattern per item. The result channel (m_valid,
//   m_ready, m_character, m_kind, m_last) returns the text one character per
//   item, with m_last high on the final character of each value.
//   The value is printed with a sign, the integer digits and three
//   fraction digits; NaN, infinities and overflow give fixed words.
// Timing:
//   One value is handled at a time. After acceptance, the scale state
//   scales the mantissa, the conversion state converts to decimal at four
//   bits per cycle through the double dabble unit, and the prepare state
//   selects the first character. Characters then leave at one per cycle
//   while the receiver does not stall.
// Reset and stalls:
//   A synchronous active-low reset returns the unit to idle with no result
//   pending. When the receiver holds m_ready low, the current character is
//   held in the output register and the sequence pauses; the next value is
//   accepted while the final character of the previous one is still waiting.
module float_to_milli_decimal_text_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ftmd_pkg::FLOAT_W-1:0]     s_float_bits,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ftmd_pkg::CHAR_W-1:0]      m_character,
    output logic [ftmd_pkg::KIND_W-1:0]      m_kind,
    output logic                             m_last
);

    ftmd_pkg::dp_cmd_t cmd;
    ftmd_pkg::dp_sts_t sts;

    ftmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ftmd_dp u_dp (
        .aclk         (aclk),
        .s_float_bits (s_float_bits),
        .cmd          (cmd),
        .sts          (sts),
        .m_character  (m_character),
        .m_kind       (m_kind),
        .m_last       (m_last)
    );

    a_idle_only_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && m_valid) |-> m_last)
        else $error("New item accepted while a text was unfinished.");

    a_accept_no_new_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!m_valid || m_last))
        else $error("Character produced too early after acceptance.");

    a_kind_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_kind == $past(m_kind)))
        else $error("Kind changed within one text.");

    a_output_pointer_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (cmd.ptr <= sts.last_ptr))
        else $error("Character position beyond end of text.");

endmodule
